FILE: rtl/tcc_pkg.sv
package tcc_pkg;

	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int POS_W     = 8;
	localparam int CELL_W    = 16;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUT_CUR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUT_AT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;

	typedef struct packed {
		logic [CELL_W-1:0] cell_word;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
	} res_t;

endpackage

FILE: rtl/tcc_cell_mem.sv
module tcc_cell_mem #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [tcc_pkg::CELL_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [tcc_pkg::CELL_W-1:0] rdata
);

	logic [tcc_pkg::CELL_W-1:0] mem_q [DEPTH];
	logic [tcc_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tcc_seq.sv
module tcc_seq #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcc_pkg::CMD_W-1:0]   cmd,
	input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcc_pkg::POS_W-1:0]   col_x,
	input  logic [tcc_pkg::POS_W-1:0]   row_y,
	input  logic [tcc_pkg::CHAR_W-1:0]  attr,
	output logic                        res_valid,
	input  logic                        res_ready,
	output tcc_pkg::res_t               res
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
	localparam logic [AW-1:0] SCR_LAST = AW'(CELLS - COLUMNS - 1);
	localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);
	localparam logic [tcc_pkg::COL_W-1:0] COL_LAST = tcc_pkg::COL_W'(COLUMNS - 1);
	localparam logic [tcc_pkg::ROW_W-1:0] ROW_LAST = tcc_pkg::ROW_W'(ROWS - 1);

	localparam logic [3:0] ST_INIT    = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_EXEC    = 4'd2;
	localparam logic [3:0] ST_RDW     = 4'd3;
	localparam logic [3:0] ST_CLR     = 4'd4;
	localparam logic [3:0] ST_SCR_RD  = 4'd5;
	localparam logic [3:0] ST_SCR_WR  = 4'd6;
	localparam logic [3:0] ST_SCR_BLK = 4'd7;
	localparam logic [3:0] ST_DONE    = 4'd8;

	logic [3:0]                    state_q;
	logic [AW-1:0]                 idx_q;
	logic [tcc_pkg::COL_W-1:0]     cur_col_q;
	logic [tcc_pkg::ROW_W-1:0]     cur_row_q;
	logic [tcc_pkg::CMD_W-1:0]     cmd_q;
	logic [tcc_pkg::CHAR_W-1:0]    char_q;
	logic [tcc_pkg::POS_W-1:0]     x_q;
	logic [tcc_pkg::POS_W-1:0]     y_q;
	logic [tcc_pkg::CELL_W-1:0]    word_q;

	logic [tcc_pkg::POS_W-1:0]     col_sel;
	logic [tcc_pkg::POS_W-1:0]     row_sel;
	logic [AW-1:0]                 pos_addr;
	logic                          in_range;
	logic [tcc_pkg::CELL_W-1:0]    blank_cell;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [tcc_pkg::CELL_W-1:0]    mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	logic [tcc_pkg::CELL_W-1:0]    mem_rdata;
	logic                          row_adv;

	tcc_cell_mem #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		if (cmd_q == tcc_pkg::CMD_PUT_CUR) begin
			col_sel = tcc_pkg::POS_W'(cur_col_q);
			row_sel = tcc_pkg::POS_W'(cur_row_q);
		end else begin
			col_sel = x_q;
			row_sel = y_q;
		end
		pos_addr   = AW'(32'(row_sel) * 32'(COLUMNS) + 32'(col_sel));
		in_range   = (x_q < tcc_pkg::POS_W'(COLUMNS)) && (y_q < tcc_pkg::POS_W'(ROWS));
		blank_cell = {attr, tcc_pkg::CHAR_BLANK};
		row_adv    = (char_q == tcc_pkg::CHAR_NEWLINE) || (cur_col_q == COL_LAST);

		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = blank_cell;
		mem_raddr = pos_addr;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			ST_EXEC: begin
				mem_waddr = pos_addr;
				mem_wdata = {attr, char_q};
				case (cmd_q)
					tcc_pkg::CMD_PUT_CUR: mem_we = (char_q != tcc_pkg::CHAR_NEWLINE);
					tcc_pkg::CMD_PUT_AT:  mem_we = in_range;
					default:              mem_we = 1'b0;
				endcase
			end
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_SCR_RD: begin
				mem_raddr = idx_q + ROW_STEP;
			end
			ST_SCR_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			ST_SCR_BLK: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			idx_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (cmd_q)
						tcc_pkg::CMD_PUT_CUR: begin
							if (row_adv) begin
								cur_col_q <= '0;
								if (cur_row_q == ROW_LAST) begin
									idx_q   <= '0;
									state_q <= ST_SCR_RD;
								end else begin
									cur_row_q <= cur_row_q + 1'b1;
								end
							end else begin
								cur_col_q <= cur_col_q + 1'b1;
							end
						end
						tcc_pkg::CMD_CLEAR: begin
							cur_col_q <= '0;
							cur_row_q <= '0;
							idx_q     <= '0;
							state_q   <= ST_CLR;
						end
						tcc_pkg::CMD_READ: begin
							if (in_range) begin
								state_q <= ST_RDW;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_RDW: begin
					state_q <= ST_DONE;
				end
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == SCR_LAST) ? ST_SCR_BLK : ST_SCR_RD;
				end
				ST_SCR_BLK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q  <= cmd;
			char_q <= char_code;
			x_q    <= col_x;
			y_q    <= row_y;
		end
		if (state_q == ST_EXEC) begin
			word_q <= '0;
		end else if (state_q == ST_RDW) begin
			word_q <= mem_rdata;
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign res_valid      = (state_q == ST_DONE);
	assign res.cell_word  = word_q;
	assign res.cursor_col = cur_col_q;
	assign res.cursor_row = cur_row_q;

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr <= LAST_IDX))
		else $error("cell write address beyond the store");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q <= COL_LAST) && (cur_row_q <= ROW_LAST))
		else $error("cursor outside the screen");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted item not executed");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && in_ready))
		else $error("result pending while taking a new item");

endmodule

FILE: rtl/text_console_cursor_scroll_core.sv
// Text console engine with a COLUMNS x ROWS store of 16-bit cells held in one
// memory with a single write port and a registered read port; a small
// sequencer walks that port for every command and the block takes one item
// at a time. A put at the cursor or at a position passes from an execute
// state to a done state that holds the result, and a read of a cell on the
// screen adds a read-wait state between the two (a read outside it does not).
// A clear writes a blank to every cell of the store before its result. A put
// at the cursor that passes the last row scrolls the store and then blanks the
// last row; each moved cell needs one read and one write on the same memory.
// After reset a clearing pass writes zero to every cell, one cell per cycle;
// no item is accepted until it ends, while configuration writes are taken at
// any time. The result register lets the next item enter while a result still
// waits to be taken.
module text_console_cursor_scroll_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcc_pkg::COLOR_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tcc_pkg::CMD_W-1:0]       cmd,
	input  logic [tcc_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcc_pkg::POS_W-1:0]       col_x,
	input  logic [tcc_pkg::POS_W-1:0]       row_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tcc_pkg::CELL_W-1:0]      cell_word,
	output logic [tcc_pkg::COL_W-1:0]       cursor_col,
	output logic [tcc_pkg::ROW_W-1:0]       cursor_row
);

	logic [tcc_pkg::COLOR_W-1:0] fg_q;
	logic [tcc_pkg::COLOR_W-1:0] bg_q;
	logic                        out_valid_q;
	tcc_pkg::res_t               out_q;
	tcc_pkg::res_t               res;
	logic                        res_valid;
	logic                        res_ready;

	tcc_seq #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.char_code(char_code),
		.col_x    (col_x),
		.row_y    (row_y),
		.attr     ({bg_q, fg_q}),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q        <= '0;
			bg_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == tcc_pkg::CFG_FG_COLOR) begin
					fg_q <= cfg_data;
				end else if (cfg_index == tcc_pkg::CFG_BG_COLOR) begin
					bg_q <= cfg_data;
				end
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_word  = out_q.cell_word;
	assign cursor_col = out_q.cursor_col;
	assign cursor_row = out_q.cursor_row;

endmodule
